FILE: design/sapp_pkg.sv
package sapp_pkg;

  localparam int POINTS_DEFAULT = 100;
  localparam int DATA_W = 32;
  localparam int PERIOD_W = 24;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 24'hFFFFFF;
  localparam logic [35:0] US_PER_S_Q16 = 36'd65536000000;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_MIN_VEL = 2'd1;
  localparam logic [1:0] REG_LOW_TIME = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_IDX_DIV,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_PER_DIV,
    ST_FINISH,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_write;
    logic start_init;
    logic tick_update;
    logic idx_div_start;
    logic table_read;
    logic mul_exec;
    logic sum_exec;
    logic per_div_start;
    logic step_finish;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic step_due;
    logic idx_div_done;
    logic per_div_done;
  } dp_status_t;

endpackage

FILE: design/sapp_ctrl.sv
module sapp_ctrl
  import sapp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic out_pend, out_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      out_pend <= out_pend_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (status.step_due)
          state_next = ST_IDX_DIV;
        else
          state_next = ST_OUT;
      end
      ST_IDX_DIV: if (status.idx_div_done) state_next = ST_READ;
      ST_READ: state_next = ST_MUL;
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_PER_DIV;
      ST_PER_DIV: if (status.per_div_done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: if (!out_pend || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_pend_next = out_pend && !out_ready;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DECODE: begin
        cmd.load_write = (action == ACT_LOAD);
        cmd.start_init = (action == ACT_START);
        cmd.tick_update = (action == ACT_TICK);
        if (status.step_due)
          cmd.idx_div_start = 1'b1;
      end
      ST_IDX_DIV: cmd.table_read = status.idx_div_done;
      ST_READ: cmd.mul_exec = 1'b1;
      ST_MUL: cmd.sum_exec = 1'b1;
      ST_SUM: cmd.per_div_start = 1'b1;
      ST_FINISH: cmd.step_finish = 1'b1;
      ST_OUT: begin
        if (!out_pend || out_ready) begin
          cmd.out_load = 1'b1;
          out_pend_next = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid = out_pend;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("accept while working");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load_gate: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_pend || out_ready)) else $error("result overwritten");

endmodule

FILE: design/sapp_divider.sv
module sapp_divider #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic             active;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] shreg;
  logic [DEN_W:0]   trial;

  always_comb trial = {rem[DEN_W-1:0], shreg[NUM_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (active) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      shreg <= num;
    end else if (active) begin
      if (!trial[DEN_W]) begin
        rem <= trial;
        shreg <= {shreg[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-1:0], shreg[NUM_W-1]};
        shreg <= {shreg[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = shreg;

endmodule

FILE: design/sapp_datapath.sv
module sapp_datapath
  import sapp_pkg::*;
#(
  parameter int POINTS = POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [1:0]          action,
  input  logic [6:0]          entry_index,
  input  logic signed [31:0]  accel_value,
  input  logic                clockwise,
  input  logic [15:0]         step_count,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                step_level,
  output logic                direction_level,
  output logic                busy_res,
  output logic                move_done,
  output logic [PERIOD_W-1:0] period_us
);

  localparam int IDX_W = $clog2(POINTS);
  localparam int PN_W = 16 + IDX_W + 1;

  logic [15:0] time_step;
  logic [31:0] min_vel;
  logic [7:0]  low_time;

  logic [31:0] table_mem [POINTS];
  logic [POINTS-1:0] entry_valid;
  logic [31:0] accel_rd;
  logic        rd_valid;

  logic [31:0] velocity;
  logic [15:0] step_number, steps_in_move;
  logic        direction_reg;
  logic        ph_high, ph_busy;
  logic [PERIOD_W-1:0] phase_counter, high_time;
  logic        done_flag;
  logic [47:0] prod;

  logic [PN_W-1:0] idx_quot;
  logic            idx_done;
  logic [35:0]     per_quot;
  logic            per_done;
  logic [IDX_W-1:0] idx;
  logic [PERIOD_W-1:0] cnt_dec;
  logic [15:0] step_inc;
  logic        load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd262;
      min_vel <= 32'd6554;
      low_time <= 8'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data[15:0];
        REG_MIN_VEL: min_vel <= cfg_data;
        REG_LOW_TIME: low_time <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_dec = (phase_counter != '0) ? phase_counter - 1'b1 : phase_counter;
    step_inc = step_number + 16'd1;
    status.step_due = (action == ACT_START && !ph_busy && step_count != '0)
                      || (action == ACT_TICK && ph_busy && !ph_high && cnt_dec == '0
                          && step_inc < steps_in_move);
    status.idx_div_done = idx_done;
    status.per_div_done = per_done;
    if (idx_quot >= PN_W'(POINTS)) idx = IDX_W'(POINTS - 1);
    else idx = idx_quot[IDX_W-1:0];
    load_ok = cmd.load_write && !ph_busy && (32'(entry_index) < POINTS);
  end

  sapp_divider #(.NUM_W(PN_W), .DEN_W(16)) u_idx_div (
    .clk(clk), .rst(rst), .start(cmd.idx_div_start),
    .num(PN_W'({16'(cmd.start_init ? 16'd0 : step_inc)} * POINTS)),
    .den(cmd.start_init ? step_count : steps_in_move),
    .done(idx_done), .quot(idx_quot)
  );

  sapp_divider #(.NUM_W(36), .DEN_W(32)) u_per_div (
    .clk(clk), .rst(rst), .start(cmd.per_div_start),
    .num(US_PER_S_Q16), .den(velocity),
    .done(per_done), .quot(per_quot)
  );

  always_ff @(posedge clk) begin
    if (load_ok)
      table_mem[IDX_W'(entry_index)] <= accel_value;
    if (cmd.table_read) accel_rd <= table_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (load_ok)
        entry_valid[IDX_W'(entry_index)] <= 1'b1;
      if (cmd.table_read) rd_valid <= entry_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity <= '0;
      step_number <= '0;
      steps_in_move <= '0;
      direction_reg <= 1'b0;
      ph_high <= 1'b0;
      ph_busy <= 1'b0;
      phase_counter <= '0;
      high_time <= '0;
      done_flag <= 1'b0;
      step_level <= 1'b0;
      direction_level <= 1'b0;
      busy_res <= 1'b0;
      move_done <= 1'b0;
      period_us <= '0;
    end else begin
      if (cmd.start_init && !ph_busy) begin
        direction_reg <= clockwise;
        steps_in_move <= step_count;
        step_number <= '0;
        velocity <= '0;
        done_flag <= (step_count == '0);
        high_time <= '0;
      end
      if (cmd.tick_update && ph_busy) begin
        if (cnt_dec != '0) begin
          phase_counter <= cnt_dec;
        end else if (ph_high) begin
          ph_high <= 1'b0;
          phase_counter <= PERIOD_W'((low_time != '0) ? low_time : 8'd1);
        end else begin
          step_number <= step_inc;
          phase_counter <= '0;
          if (!(step_inc < steps_in_move)) begin
            ph_busy <= 1'b0;
            high_time <= '0;
            done_flag <= 1'b1;
          end
        end
      end
      if (cmd.mul_exec)
        prod <= 48'($signed(rd_valid ? accel_rd : 32'd0) * $signed({1'b0, time_step}));
      if (cmd.sum_exec) begin
        logic signed [33:0] s;
        logic [31:0] vmin;
        vmin = (min_vel != '0) ? min_vel : 32'd1;
        s = $signed({2'b00, velocity}) + $signed({{2{prod[47]}}, prod[47:16]});
        if (s < $signed({2'b00, vmin})) velocity <= vmin;
        else if (s > $signed(34'h0FFFFFFFF)) velocity <= 32'hFFFFFFFF;
        else velocity <= s[31:0];
      end
      if (cmd.step_finish) begin
        logic [PERIOD_W-1:0] per;
        if (per_quot > 36'(PERIOD_MAX)) per = PERIOD_MAX;
        else if (per_quot == '0) per = PERIOD_W'(1);
        else per = per_quot[PERIOD_W-1:0];
        high_time <= per;
        phase_counter <= per;
        ph_high <= 1'b1;
        ph_busy <= 1'b1;
      end
      if (cmd.out_load) begin
        step_level <= ph_high;
        direction_level <= direction_reg;
        busy_res <= ph_busy;
        move_done <= done_flag;
        period_us <= ph_busy ? high_time : '0;
        done_flag <= 1'b0;
      end
    end
  end

  a_busy_counter: assert property (@(posedge clk) disable iff (rst)
    ph_high |-> ph_busy) else $error("high phase while idle");
  a_vel_floor: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.sum_exec) |-> velocity != '0) else $error("zero velocity");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cmd.table_read |-> 32'(idx) < POINTS) else $error("index out of table");

endmodule

FILE: design/stepper_accel_profile_pulser.sv
// Step-pulse generator for a stepper motor following a table of signed Q16.16
// accelerations. Each input word (load, start or one-microsecond tick) yields
// one result word with the pin levels after it. Loads and plain ticks skip
// both dividers; a word that begins a step runs the bit-serial index divider
// and then the reciprocal divider for the high time. A result word still
// waiting on the output adds its wait to the next word. The table reads as
// zero until written; no clearing pass is needed.
module stepper_accel_profile_pulser
  import sapp_pkg::*;
#(
  parameter int PROFILE_POINTS = POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [6:0]          entry_index,
  input  logic signed [31:0]  accel_value,
  input  logic                clockwise,
  input  logic [15:0]         step_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                step_level,
  output logic                direction_level,
  output logic                busy_res,
  output logic                move_done,
  output logic [PERIOD_W-1:0] period_us,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [1:0]         action_q;
  logic [6:0]         entry_q;
  logic signed [31:0] accel_q;
  logic               cw_q;
  logic [15:0]        count_q;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_q <= action;
      entry_q <= entry_index;
      accel_q <= accel_value;
      cw_q <= clockwise;
      count_q <= step_count;
    end
  end

  sapp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .action(action_q), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  sapp_datapath #(.POINTS(PROFILE_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .action(action_q), .entry_index(entry_q), .accel_value(accel_q),
    .clockwise(cw_q), .step_count(count_q),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .step_level(step_level), .direction_level(direction_level),
    .busy_res(busy_res), .move_done(move_done), .period_us(period_us)
  );

endmodule
